/* rtl/dswc_pkg.sv */
package dswc_pkg;

    // event codes
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_MOTION    = 2'd1;
    localparam logic [1:0] OP_FORCE_ON  = 2'd2;
    localparam logic [1:0] OP_FORCE_OFF = 2'd3;

    // panel commands
    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_SLEEP_IN  = 2'd1;
    localparam logic [1:0] CMD_SLEEP_OUT = 2'd2;

    // register indexes
    localparam logic [1:0] REG_IDLE_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE      = 2'd1;
    localparam logic [1:0] REG_WAKE_THRESH   = 2'd2;
    localparam logic [1:0] REG_CONFIRM_COUNT = 2'd3;

    // register reset values
    localparam logic [31:0] RST_IDLE_TIMEOUT  = 32'd10000;
    localparam logic [31:0] RST_DEBOUNCE      = 32'd2000;
    localparam logic [15:0] RST_WAKE_THRESH   = 16'd256;
    localparam logic [7:0]  RST_CONFIRM_COUNT = 8'd3;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic [31:0] idle_timeout_ms;
        logic [31:0] debounce_ms;
        logic [15:0] wake_threshold;
        logic [7:0]  confirm_count;
    } t_cfg;

    typedef struct packed {
        logic        is_on;
        logic [31:0] activity_stamp;
        logic [31:0] off_stamp;
        logic [7:0]  wake_run;
    } t_state;

    typedef struct packed {
        logic [15:0] motion_level;
        logic [31:0] now_ms;
        logic [1:0]  op;
    } t_item;

    typedef struct packed {
        logic [7:0] confirm_progress;
        logic [1:0] panel_command;
        logic       display_on;
    } t_result;

endpackage

/* rtl/dswc_step.sv */
module dswc_step (
    input  dswc_pkg::t_cfg    i_cfg,
    input  dswc_pkg::t_state  i_state,
    input  dswc_pkg::t_item   i_item,
    output dswc_pkg::t_state  o_state,
    output dswc_pkg::t_result o_result
);

    logic        above;
    logic [31:0] idle_age;
    logic [31:0] off_age;
    logic [7:0]  run_inc;
    logic [1:0]  cmd;

    assign above    = i_item.motion_level > i_cfg.wake_threshold;
    assign idle_age = i_item.now_ms - i_state.activity_stamp;
    assign off_age  = i_item.now_ms - i_state.off_stamp;
    assign run_inc  = i_state.wake_run + 8'd1;

    always_comb begin
        o_state = i_state;
        cmd     = dswc_pkg::CMD_NONE;
        unique case (i_item.op)
            dswc_pkg::OP_TICK: begin
                if (!i_state.is_on) begin
                    if (i_state.off_stamp == 32'd0) begin
                        o_state.off_stamp = i_item.now_ms;
                    end
                end else if (i_state.activity_stamp == 32'd0) begin
                    o_state.activity_stamp = i_item.now_ms;
                end else if (idle_age >= i_cfg.idle_timeout_ms) begin
                    o_state.is_on     = 1'b0;
                    o_state.off_stamp = 32'd0;
                    o_state.wake_run  = 8'd0;
                    cmd               = dswc_pkg::CMD_SLEEP_IN;
                end
            end
            dswc_pkg::OP_MOTION: begin
                if (i_state.is_on) begin
                    if (above) begin
                        o_state.activity_stamp = 32'd0;
                    end
                end else if (i_state.off_stamp != 32'd0 && off_age >= i_cfg.debounce_ms) begin
                    if (above) begin
                        if (run_inc >= i_cfg.confirm_count) begin
                            o_state.is_on          = 1'b1;
                            o_state.wake_run       = 8'd0;
                            o_state.activity_stamp = 32'd0;
                            cmd                    = dswc_pkg::CMD_SLEEP_OUT;
                        end else begin
                            o_state.wake_run = run_inc;
                        end
                    end else begin
                        o_state.wake_run = 8'd0;
                    end
                end
            end
            dswc_pkg::OP_FORCE_ON: begin
                if (!i_state.is_on) begin
                    o_state.is_on    = 1'b1;
                    o_state.wake_run = 8'd0;
                    cmd              = dswc_pkg::CMD_SLEEP_OUT;
                end
                o_state.activity_stamp = 32'd0;
            end
            dswc_pkg::OP_FORCE_OFF: begin
                if (i_state.is_on) begin
                    o_state.is_on     = 1'b0;
                    o_state.off_stamp = 32'd0;
                    o_state.wake_run  = 8'd0;
                    cmd               = dswc_pkg::CMD_SLEEP_IN;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    assign o_result.display_on       = o_state.is_on;
    assign o_result.panel_command    = cmd;
    assign o_result.confirm_progress = o_state.wake_run;

endmodule

/* rtl/display_idle_sleep_wake_controller_top.sv */
// channel   | dir | handshake                   | payload (lowest bits first)
// ----------+-----+-----------------------------+----------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready | op[1:0], now_ms[33:2], motion_level[49:34]
// m_axis    | out | m_axis_tvalid/m_axis_tready | display_on[0], panel_command[2:1],
//           |     |                             | confirm_progress[10:3]
// cfg       | in  | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_data
//
// one event per cycle sustained while m_axis_tready stays high; an accepted request
// shows on m_axis once it has passed through both registers
// (input register, then the state update and result register)
// the state registers are updated in the same edge that loads the result register
// synchronous active-low reset: display on, stamps unseeded, registers at defaults
// a stalled output holds; the input register keeps taking requests while the output
// register drains, s_axis_tready drops only when both stages are full
module display_idle_sleep_wake_controller_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [31:0]                      i_cfg_data,
    // event stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dswc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // op, now_ms, motion_level, zero pad
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dswc_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // display_on, panel_command,
                                                            // confirm_progress, zero pad
);

    // configuration registers
    dswc_pkg::t_cfg    r_cfg;

    // controller state
    dswc_pkg::t_state  r_state;
    dswc_pkg::t_state  n_state;

    // input stage
    logic              r_in_valid;
    dswc_pkg::t_item   r_item;

    // output stage
    logic              r_out_valid;
    dswc_pkg::t_result r_result;
    dswc_pkg::t_result n_result;

    logic              out_free;
    logic              advance;

    // output slot empties or is being taken this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout_ms <= dswc_pkg::RST_IDLE_TIMEOUT;
            r_cfg.debounce_ms     <= dswc_pkg::RST_DEBOUNCE;
            r_cfg.wake_threshold  <= dswc_pkg::RST_WAKE_THRESH;
            r_cfg.confirm_count   <= dswc_pkg::RST_CONFIRM_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dswc_pkg::REG_IDLE_TIMEOUT:  r_cfg.idle_timeout_ms <= i_cfg_data;
                dswc_pkg::REG_DEBOUNCE:      r_cfg.debounce_ms     <= i_cfg_data;
                dswc_pkg::REG_WAKE_THRESH:   r_cfg.wake_threshold  <= i_cfg_data[15:0];
                dswc_pkg::REG_CONFIRM_COUNT: r_cfg.confirm_count   <= i_cfg_data[7:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // input register: loads whenever the handshake completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.op           <= s_axis_tdata[1:0];
            r_item.now_ms       <= s_axis_tdata[33:2];
            r_item.motion_level <= s_axis_tdata[49:34];
        end
    end

    // next state and result for the event in the input register
    dswc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.is_on          <= 1'b1;
            r_state.activity_stamp <= 32'd0;
            r_state.off_stamp      <= 32'd0;
            r_state.wake_run       <= 8'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_result.confirm_progress, r_result.panel_command,
                            r_result.display_on};

    // a wake command always leaves the display on
    a_sleep_out_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.panel_command == dswc_pkg::CMD_SLEEP_OUT
        |-> r_result.display_on)
        else $error("sleep-out reported with display off");

    // a sleep command always leaves the display off
    a_sleep_in_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.panel_command == dswc_pkg::CMD_SLEEP_IN
        |-> !r_result.display_on)
        else $error("sleep-in reported with display on");

    // the wake counter only runs while the display is off
    a_run_idle_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.is_on |-> r_state.wake_run == 8'd0)
        else $error("wake counter nonzero while display on");

    // a stalled result is not overwritten by the next event
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> $stable(r_result) && $stable(r_state))
        else $error("result or state changed under output stall");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import dswc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // one row of the directed walk: a request, and a typed-in result where it is obvious
    typedef struct packed {
        logic    typed;
        t_result res;
        t_item   req;
    } t_walk_row;

    // register setting and traffic mix of one random phase
    typedef struct packed {
        logic [31:0] timeout;
        logic [31:0] debounce;
        logic [15:0] thresh;
        logic [7:0]  confirm;
        logic [31:0] step_max;
        int unsigned items;
        int unsigned motion_pct;
        int unsigned force_pct;
        int unsigned above_pct;
        int unsigned noise_pct;
    } t_phase;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [1:0]             i_cfg_idx = REG_IDLE_TIMEOUT;
    logic [31:0]            i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // op, now_ms, motion_level, zero pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // display_on, panel_command, confirm_progress

    display_idle_sleep_wake_controller_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // power state predictor: own copy of the panel state and the registers
    // ------------------------------------------------------------------
    t_cfg        pwr_cfg = '{RST_IDLE_TIMEOUT, RST_DEBOUNCE, RST_WAKE_THRESH,
                             RST_CONFIRM_COUNT};
    logic        pwr_on = 1'b1;
    logic [31:0] pwr_activity = '0;   // zero reads as unseeded
    logic [31:0] pwr_off_at = '0;     // zero reads as unseeded
    logic [7:0]  pwr_wake_run = '0;

    t_result pending_panel_results[$];
    int      n_fail = 0;
    int      cycles = 0;

    function automatic logic [1:0] enter_sleep();
        if (!pwr_on) return CMD_NONE;
        pwr_on       = 1'b0;
        pwr_off_at   = '0;
        pwr_wake_run = '0;
        return CMD_SLEEP_IN;
    endfunction

    function automatic logic [1:0] leave_sleep();
        logic [1:0] cmd;
        cmd = CMD_NONE;
        if (!pwr_on) begin
            pwr_on       = 1'b1;
            pwr_wake_run = '0;
            cmd          = CMD_SLEEP_OUT;
        end
        // any wake or forced on restarts the idle timer from the next tick
        pwr_activity = '0;
        return cmd;
    endfunction

    function automatic t_result panel_power_step(t_item req);
        logic        above;
        logic [31:0] idle_for;
        logic [31:0] off_for;
        t_result     r;
        above    = req.motion_level > pwr_cfg.wake_threshold;
        idle_for = req.now_ms - pwr_activity;   // wraps modulo 2^32
        off_for  = req.now_ms - pwr_off_at;
        r.panel_command = CMD_NONE;
        case (req.op)
            OP_TICK: begin
                if (!pwr_on) begin
                    if (pwr_off_at == '0) pwr_off_at = req.now_ms;
                end else if (pwr_activity == '0) begin
                    pwr_activity = req.now_ms;
                end else if (idle_for >= pwr_cfg.idle_timeout_ms) begin
                    r.panel_command = enter_sleep();
                end
            end
            OP_MOTION: begin
                if (pwr_on) begin
                    if (above) pwr_activity = '0;
                end else if (pwr_off_at != '0 && off_for >= pwr_cfg.debounce_ms) begin
                    // only past the debounce window does motion count toward a wake
                    if (above) begin
                        pwr_wake_run = pwr_wake_run + 8'd1;
                        if (pwr_wake_run >= pwr_cfg.confirm_count)
                            r.panel_command = leave_sleep();
                    end else begin
                        pwr_wake_run = '0;
                    end
                end
            end
            OP_FORCE_ON:  r.panel_command = leave_sleep();
            default:      r.panel_command = enter_sleep();
        endcase
        r.display_on       = pwr_on;
        r.confirm_progress = pwr_wake_run;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: check every accepted result, stall on a pattern of its own
    // ------------------------------------------------------------------
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    task automatic match_panel_result(t_result got);
        t_result want;
        if (pending_panel_results.size() == 0) begin
            $display("%0t: result with no request outstanding, expected none, got %h",
                     $time, got);
            n_fail++;
        end else begin
            want = pending_panel_results.pop_front();
            if (got.display_on !== want.display_on) begin
                $display("%0t: display_on expected %0d got %0d",
                         $time, want.display_on, got.display_on);
                n_fail++;
            end
            if (got.panel_command !== want.panel_command) begin
                $display("%0t: panel_command expected %0d got %0d",
                         $time, want.panel_command, got.panel_command);
                n_fail++;
            end
            if (got.confirm_progress !== want.confirm_progress) begin
                $display("%0t: confirm_progress expected %0d got %0d",
                         $time, want.confirm_progress, got.confirm_progress);
                n_fail++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        // values read here are the ones that stood at this edge
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            match_panel_result(t_result'(m_axis_tdata[$bits(t_result)-1:0]));

        // stall modes: always ready, mostly ready, one in four, mostly stalled
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 99) < 70);
            2:       m_axis_tready <= (cycles % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 99) < 25);
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    logic [31:0] clock_ms = 32'd1;

    // hand one request to the block in bursts with random gaps; called just after an edge
    task automatic push_request(t_item req, logic typed, t_result typed_res);
        int unsigned gap;
        t_result     r;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(req);
        do @(posedge i_clk); while (!s_axis_tready);
        // predictor runs on every request so that its state follows the block
        r = panel_power_step(req);
        pending_panel_results.push_back(typed ? typed_res : r);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_panel_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_IDLE_TIMEOUT: pwr_cfg.idle_timeout_ms = data;
            REG_DEBOUNCE:     pwr_cfg.debounce_ms     = data;
            REG_WAKE_THRESH:  pwr_cfg.wake_threshold  = data[15:0];
            default:          pwr_cfg.confirm_count   = data[7:0];
        endcase
    endtask

    function automatic t_walk_row walk_row(logic [1:0] op, logic [31:0] now_ms,
                                           logic [15:0] level, logic typed,
                                           logic on, logic [1:0] cmd, logic [7:0] prog);
        t_walk_row w;
        w.req   = '{motion_level: level, now_ms: now_ms, op: op};
        w.typed = typed;
        w.res   = '{confirm_progress: prog, panel_command: cmd, display_on: on};
        return w;
    endfunction

    // one random request shaped by the phase: mostly a plausible event stream
    // with a clock that moves forward, now and then pure noise
    function automatic t_item random_request(t_phase p);
        t_item       req;
        int unsigned pick;
        if ($urandom_range(0, 99) < p.noise_pct) begin
            req.op           = 2'($urandom_range(0, 3));
            req.now_ms       = $urandom;
            req.motion_level = 16'($urandom);
            return req;
        end
        clock_ms = clock_ms + ((p.step_max == '1) ? $urandom : $urandom_range(0, p.step_max));
        req.now_ms = clock_ms;
        pick = $urandom_range(0, 99);
        if (pick < p.motion_pct)
            req.op = OP_MOTION;
        else if (pick < p.motion_pct + p.force_pct)
            req.op = $urandom_range(0, 1) ? OP_FORCE_ON : OP_FORCE_OFF;
        else
            req.op = OP_TICK;
        if ($urandom_range(0, 99) < p.above_pct && p.thresh != 16'hFFFF)
            req.motion_level = 16'($urandom_range(int'(p.thresh) + 1, 16'hFFFF));
        else
            req.motion_level = 16'($urandom_range(0, p.thresh));
        return req;
    endfunction

    t_walk_row walk[25];
    t_phase    phases[6];

    initial begin
        t_item   req;
        t_result no_res;
        no_res = '0;

        // directed walk at the reset register values: 10 s idle, 2 s debounce,
        // threshold 1.0, three samples to wake
        walk[0]  = walk_row(OP_TICK,      32'd0,        16'h0000, 1, 1, CMD_NONE,      0);
        walk[1]  = walk_row(OP_TICK,      32'd100,      16'hFFFF, 1, 1, CMD_NONE,      0);
        walk[2]  = walk_row(OP_TICK,      32'd10099,    16'h0000, 1, 1, CMD_NONE,      0);
        walk[3]  = walk_row(OP_MOTION,    32'd10099,    16'h0101, 1, 1, CMD_NONE,      0);
        walk[4]  = walk_row(OP_TICK,      32'd10100,    16'h0000, 1, 1, CMD_NONE,      0);
        walk[5]  = walk_row(OP_MOTION,    32'd15000,    16'h0100, 1, 1, CMD_NONE,      0);
        walk[6]  = walk_row(OP_TICK,      32'd20100,    16'h0000, 1, 0, CMD_SLEEP_IN,  0);
        walk[7]  = walk_row(OP_MOTION,    32'd20200,    16'hFFFF, 1, 0, CMD_NONE,      0);
        walk[8]  = walk_row(OP_TICK,      32'd20200,    16'h0000, 1, 0, CMD_NONE,      0);
        walk[9]  = walk_row(OP_MOTION,    32'd22199,    16'hFFFF, 1, 0, CMD_NONE,      0);
        walk[10] = walk_row(OP_MOTION,    32'd22200,    16'hFFFF, 0, 0, CMD_NONE,      0);
        walk[11] = walk_row(OP_MOTION,    32'd22201,    16'h8000, 0, 0, CMD_NONE,      0);
        walk[12] = walk_row(OP_MOTION,    32'd22202,    16'h0000, 0, 0, CMD_NONE,      0);
        walk[13] = walk_row(OP_MOTION,    32'd22203,    16'hFFFF, 0, 0, CMD_NONE,      0);
        walk[14] = walk_row(OP_MOTION,    32'd22204,    16'h0101, 0, 0, CMD_NONE,      0);
        walk[15] = walk_row(OP_MOTION,    32'd22205,    16'hFFFF, 1, 1, CMD_SLEEP_OUT, 0);
        walk[16] = walk_row(OP_FORCE_ON,  32'd22206,    16'h0000, 1, 1, CMD_NONE,      0);
        walk[17] = walk_row(OP_FORCE_OFF, 32'd22207,    16'h0000, 1, 0, CMD_SLEEP_IN,  0);
        walk[18] = walk_row(OP_FORCE_OFF, 32'd22208,    16'h0000, 1, 0, CMD_NONE,      0);
        walk[19] = walk_row(OP_FORCE_ON,  32'd22209,    16'h0000, 1, 1, CMD_SLEEP_OUT, 0);
        // idle timer across the wrap of the millisecond clock
        walk[20] = walk_row(OP_TICK,      32'hFFFFFFF0, 16'h0000, 1, 1, CMD_NONE,      0);
        walk[21] = walk_row(OP_TICK,      32'h00002700, 16'h0000, 1, 0, CMD_SLEEP_IN,  0);
        // debounce across the wrap too
        walk[22] = walk_row(OP_TICK,      32'hFFFFFFFF, 16'h0000, 1, 0, CMD_NONE,      0);
        walk[23] = walk_row(OP_MOTION,    32'd1999,     16'hFFFF, 1, 0, CMD_NONE,      1);
        walk[24] = walk_row(OP_FORCE_ON,  32'd2000,     16'h0000, 1, 1, CMD_SLEEP_OUT, 0);

        //                 timeout        debounce       thresh    confirm step
        //                 items motion force above noise
        phases[0] = '{32'd50,         32'd20,        16'h0100, 8'd2,   32'd8,
                       90,   55,    8,    50,   5};
        phases[1] = '{32'd1,          32'd0,         16'h0000, 8'd1,   32'd2,
                       60,   50,    10,   70,   5};
        // largest values: the timers practically never run out, nothing is above
        phases[2] = '{32'hFFFFFFFF,   32'hFFFFFFFF,  16'hFFFF, 8'd255, 32'hFFFFFFFF,
                       50,   50,    10,   50,   10};
        // longest confirmation run, fed an unbroken stream of strong motion
        phases[3] = '{32'd0,          32'd0,         16'hFFFE, 8'd255, 32'd3,
                       280,  97,    0,    100,  0};
        // zero confirm count: the first counting sample wakes
        phases[4] = '{32'd0,          32'd5,         16'h8000, 8'd0,   32'd4,
                       60,   55,    8,    50,   5};
        phases[5] = '{32'd200,        32'd100,       16'($urandom), 8'd4, 32'd30,
                       80,   55,    6,    60,   5};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (walk[k])
            push_request(walk[k].req, walk[k].typed, walk[k].res);

        foreach (phases[n]) begin
            // registers change only with the block idle
            drain_results();
            write_reg(REG_IDLE_TIMEOUT, phases[n].timeout);
            write_reg(REG_DEBOUNCE, phases[n].debounce);
            write_reg(REG_WAKE_THRESH, {16'h0, phases[n].thresh});
            write_reg(REG_CONFIRM_COUNT, {24'h0, phases[n].confirm});
            i_cfg_we <= 1'b0;

            // open with the panel asleep and its off stamp seeded
            clock_ms = clock_ms + 32'd1;
            req = '{motion_level: 16'h0, now_ms: clock_ms, op: OP_FORCE_OFF};
            push_request(req, 1'b0, no_res);
            clock_ms = clock_ms + 32'd1;
            req = '{motion_level: 16'h0, now_ms: clock_ms, op: OP_TICK};
            push_request(req, 1'b0, no_res);

            repeat (phases[n].items)
                push_request(random_request(phases[n]), 1'b0, no_res);
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (n_fail == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
